[rtl/srg_pkg.sv]
// Shared types, constants and the control program of the stepper ramp generator.
package srg_pkg;

	localparam int unsigned CNT_W  = 16;
	localparam int unsigned PER_W  = 7;
	localparam int unsigned TICK_W = 8;
	localparam int unsigned PROD_W = CNT_W + 1 + PER_W;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned STEP_W = 5;

	localparam logic [PER_W-1:0] IDLE_MARK    = 7'd100;
	localparam logic [PER_W-1:0] PERIOD_MAX   = 7'd127;
	localparam logic [PER_W-1:0] RESET_PERIOD = 7'd10;
	localparam logic [PER_W-1:0] RESET_TOP    = 7'd10;
	localparam logic [CNT_W-1:0] RESET_SCALE  = 16'd1000;
	localparam logic [1:0]       DIRS_FWD     = 2'b11;

	// register index, taken from paddr[2]
	localparam logic REG_RAMP_SCALE = 1'b0;
	localparam logic REG_TOP_PERIOD = 1'b1;

	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_IN,
		COND_CMD,
		COND_IDLE,
		COND_NO_PULSE,
		COND_ABOVE_TOP,
		COND_ACTIVE,
		COND_DECEL,
		COND_DIRCHG,
		COND_AT_TARGET,
		COND_OUT_BUSY
	} cond_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LATCH,
		ACT_SET_TARGET,
		ACT_TICK_INC,
		ACT_PULSE,
		ACT_SEEK,
		ACT_CNT_INC,
		ACT_MUL,
		ACT_APPLY,
		ACT_SAVE_PREV,
		ACT_ACCEL_START,
		ACT_DN_UP,
		ACT_DIRCHG,
		ACT_HOLD,
		ACT_LINES,
		ACT_EMIT
	} act_t;

	// skip: the action is dropped when the jump is taken
	// ret:  fall-through goes back to the wait step
	typedef struct packed {
		cond_t             cond;
		logic              skip;
		logic              ret;
		logic [STEP_W-1:0] target;
		act_t              act;
	} ucode_t;

	typedef struct packed {
		logic in_valid;
		logic cmd;
		logic idle;
		logic no_pulse;
		logic above_top;
		logic active;
		logic decel;
		logic dirchg;
		logic at_target;
		logic out_busy;
	} status_t;

	localparam logic [STEP_W-1:0] PC_WAIT     = 5'd0;
	localparam logic [STEP_W-1:0] PC_DISPATCH = 5'd1;
	localparam logic [STEP_W-1:0] PC_IDLECHK  = 5'd2;
	localparam logic [STEP_W-1:0] PC_PULSECHK = 5'd3;
	localparam logic [STEP_W-1:0] PC_TOPCHK   = 5'd4;
	localparam logic [STEP_W-1:0] PC_ACTCHK   = 5'd5;
	localparam logic [STEP_W-1:0] PC_DIRCHK   = 5'd6;
	localparam logic [STEP_W-1:0] PC_SEEK     = 5'd7;
	localparam logic [STEP_W-1:0] PC_CNT      = 5'd8;
	localparam logic [STEP_W-1:0] PC_MUL      = 5'd9;
	localparam logic [STEP_W-1:0] PC_APPLY    = 5'd10;
	localparam logic [STEP_W-1:0] PC_SAVE     = 5'd11;
	localparam logic [STEP_W-1:0] PC_ACT      = 5'd12;
	localparam logic [STEP_W-1:0] PC_ACCEL    = 5'd13;
	localparam logic [STEP_W-1:0] PC_DEC      = 5'd14;
	localparam logic [STEP_W-1:0] PC_DCHG     = 5'd15;
	localparam logic [STEP_W-1:0] PC_HOLD     = 5'd16;
	localparam logic [STEP_W-1:0] PC_LINES    = 5'd17;
	localparam logic [STEP_W-1:0] PC_DONE     = 5'd18;
	localparam logic [STEP_W-1:0] PC_CMDS     = 5'd19;

	function automatic ucode_t uw(input cond_t c, input logic s, input logic r,
			input logic [STEP_W-1:0] t, input act_t a);
		ucode_t w;
		w.cond   = c;
		w.skip   = s;
		w.ret    = r;
		w.target = t;
		w.act    = a;
		return w;
	endfunction

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			PC_WAIT:     w = uw(COND_NO_IN,     1'b1, 1'b0, PC_WAIT,   ACT_LATCH);
			PC_DISPATCH: w = uw(COND_CMD,       1'b0, 1'b0, PC_CMDS,   ACT_NONE);
			PC_IDLECHK:  w = uw(COND_IDLE,      1'b1, 1'b0, PC_DONE,   ACT_TICK_INC);
			PC_PULSECHK: w = uw(COND_NO_PULSE,  1'b1, 1'b0, PC_DONE,   ACT_PULSE);
			PC_TOPCHK:   w = uw(COND_ABOVE_TOP, 1'b0, 1'b0, PC_LINES,  ACT_NONE);
			PC_ACTCHK:   w = uw(COND_ACTIVE,    1'b0, 1'b0, PC_ACT,    ACT_NONE);
			PC_DIRCHK:   w = uw(COND_DIRCHG,    1'b0, 1'b0, PC_DCHG,   ACT_NONE);
			PC_SEEK:     w = uw(COND_AT_TARGET, 1'b1, 1'b0, PC_HOLD,   ACT_SEEK);
			PC_CNT:      w = uw(COND_NEVER,     1'b0, 1'b0, PC_WAIT,   ACT_CNT_INC);
			PC_MUL:      w = uw(COND_NEVER,     1'b0, 1'b0, PC_WAIT,   ACT_MUL);
			PC_APPLY:    w = uw(COND_NEVER,     1'b0, 1'b0, PC_WAIT,   ACT_APPLY);
			PC_SAVE:     w = uw(COND_ALWAYS,    1'b0, 1'b0, PC_LINES,  ACT_SAVE_PREV);
			PC_ACT:      w = uw(COND_DECEL,     1'b0, 1'b0, PC_DEC,    ACT_NONE);
			PC_ACCEL:    w = uw(COND_ALWAYS,    1'b0, 1'b0, PC_CNT,    ACT_ACCEL_START);
			PC_DEC:      w = uw(COND_ALWAYS,    1'b0, 1'b0, PC_CNT,    ACT_DN_UP);
			PC_DCHG:     w = uw(COND_ALWAYS,    1'b0, 1'b0, PC_LINES,  ACT_DIRCHG);
			PC_HOLD:     w = uw(COND_NEVER,     1'b0, 1'b0, PC_WAIT,   ACT_HOLD);
			PC_LINES:    w = uw(COND_NEVER,     1'b0, 1'b0, PC_WAIT,   ACT_LINES);
			PC_DONE:     w = uw(COND_OUT_BUSY,  1'b1, 1'b1, PC_DONE,   ACT_EMIT);
			PC_CMDS:     w = uw(COND_ALWAYS,    1'b0, 1'b0, PC_DONE,   ACT_SET_TARGET);
			default:     w = uw(COND_ALWAYS,    1'b0, 1'b0, PC_WAIT,   ACT_NONE);
		endcase
		return w;
	endfunction

endpackage

[rtl/srg_if.sv]
// Item channel interfaces: command/tick items in, step status items out.
interface srg_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic       left_forward;
	logic       right_forward;
	logic [3:0] speed_period;

	modport source (output valid, opcode, left_forward, right_forward, speed_period,
		input ready);
	modport sink (input valid, opcode, left_forward, right_forward, speed_period,
		output ready);
endinterface

interface srg_out_if;
	logic       valid;
	logic       ready;
	logic       step_pulse;
	logic       motor_enable;
	logic       left_dir;
	logic       right_dir;
	logic [6:0] period_now;

	modport source (output valid, step_pulse, motor_enable, left_dir, right_dir, period_now,
		input ready);
	modport sink (input valid, step_pulse, motor_enable, left_dir, right_dir, period_now,
		output ready);
endinterface

[rtl/srg_seq.sv]
// Microcode sequencer: step counter, control ROM and jump condition select.
module srg_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  srg_pkg::status_t status,
	output srg_pkg::act_t    act
);

	logic [srg_pkg::STEP_W-1:0] step_q;
	logic [srg_pkg::STEP_W-1:0] step_next;
	srg_pkg::ucode_t            cw;
	logic                       taken;

	assign cw = srg_pkg::ucode_rom(step_q);

	always_comb begin
		unique case (cw.cond)
			srg_pkg::COND_NEVER:     taken = 1'b0;
			srg_pkg::COND_ALWAYS:    taken = 1'b1;
			srg_pkg::COND_NO_IN:     taken = ~status.in_valid;
			srg_pkg::COND_CMD:       taken = status.cmd;
			srg_pkg::COND_IDLE:      taken = status.idle;
			srg_pkg::COND_NO_PULSE:  taken = status.no_pulse;
			srg_pkg::COND_ABOVE_TOP: taken = status.above_top;
			srg_pkg::COND_ACTIVE:    taken = status.active;
			srg_pkg::COND_DECEL:     taken = status.decel;
			srg_pkg::COND_DIRCHG:    taken = status.dirchg;
			srg_pkg::COND_AT_TARGET: taken = status.at_target;
			srg_pkg::COND_OUT_BUSY:  taken = status.out_busy;
			default:                 taken = 1'b0;
		endcase
	end

	always_comb begin
		if (taken) begin
			step_next = cw.target;
		end else if (cw.ret) begin
			step_next = srg_pkg::PC_WAIT;
		end else begin
			step_next = step_q + srg_pkg::STEP_W'(1);
		end
	end

	assign act = (taken && cw.skip) ? srg_pkg::ACT_NONE : cw.act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= srg_pkg::PC_WAIT;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

[rtl/srg_dp.sv]
// Datapath: motion state, ramp counters, ramp multiplier and the result register.
module srg_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  srg_pkg::act_t               act,
	input  logic [srg_pkg::CNT_W-1:0]   ramp_scale,
	input  logic [srg_pkg::PER_W-1:0]   top_period,
	output srg_pkg::status_t            status,
	srg_in_if.sink                      cmd_ch,
	srg_out_if.source                   step_ch
);

	localparam int unsigned CW = srg_pkg::CNT_W;
	localparam int unsigned PW = srg_pkg::PER_W;
	localparam int unsigned TW = srg_pkg::TICK_W;
	localparam int unsigned MW = srg_pkg::PROD_W;

	// latched item
	logic          op_q;
	logic [1:0]    req_dirs_q;
	logic [3:0]    req_period_q;

	logic [TW-1:0] tick_q;
	logic [PW-1:0] cur_q;
	logic [1:0]    cur_dirs_q;
	logic [PW-1:0] tgt_period_q;
	logic [1:0]    tgt_dirs_q;
	logic [PW-1:0] prev_period_q;
	logic [1:0]    prev_dirs_q;
	logic          decel_q;
	logic          accel_q;
	logic [CW-1:0] up_q;
	logic [CW-1:0] down_q;
	logic          pulse_q;
	logic          en_q;
	logic          left_q;
	logic          right_q;

	// ramp working registers
	logic          dn_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] prod_q;

	logic          ovalid_q;
	logic          opulse_q;
	logic          oen_q;
	logic          oleft_q;
	logic          oright_q;
	logic [PW-1:0] operiod_q;

	logic [PW-1:0] divisor;
	logic [MW-1:0] product;
	logic          reached;
	logic [PW-1:0] cur_stepped;
	logic          out_busy;

	// count >= scale / d  <=>  (count + 1) * d > scale
	assign divisor = (cur_q == '0) ? PW'(1) : cur_q;
	assign product = (MW'(cnt_q) + MW'(1)) * MW'(divisor);
	assign reached = prod_q > MW'(ramp_scale);

	always_comb begin
		if (dn_q) begin
			cur_stepped = (cur_q != '0) ? cur_q - PW'(1) : cur_q;
		end else begin
			cur_stepped = (cur_q != srg_pkg::PERIOD_MAX) ? cur_q + PW'(1) : cur_q;
		end
	end

	assign out_busy = ovalid_q && !step_ch.ready;

	always_comb begin
		status.in_valid  = cmd_ch.valid;
		status.cmd       = op_q;
		status.idle      = tgt_period_q == srg_pkg::IDLE_MARK;
		status.no_pulse  = tick_q < TW'(cur_q);
		status.above_top = cur_q > top_period;
		status.active    = accel_q || decel_q;
		status.decel     = decel_q;
		status.dirchg    = prev_dirs_q != tgt_dirs_q;
		status.at_target = cur_q == tgt_period_q;
		status.out_busy  = out_busy;
	end

	assign cmd_ch.ready = act == srg_pkg::ACT_LATCH;

	assign step_ch.valid        = ovalid_q;
	assign step_ch.step_pulse   = opulse_q;
	assign step_ch.motor_enable = oen_q;
	assign step_ch.left_dir     = oleft_q;
	assign step_ch.right_dir    = oright_q;
	assign step_ch.period_now   = operiod_q;

	always_ff @(posedge clk) begin
		case (act)
			srg_pkg::ACT_LATCH: begin
				op_q         <= cmd_ch.opcode;
				req_dirs_q   <= {cmd_ch.right_forward, cmd_ch.left_forward};
				req_period_q <= cmd_ch.speed_period;
			end
			srg_pkg::ACT_SEEK:        dn_q <= cur_q > tgt_period_q;
			srg_pkg::ACT_ACCEL_START: dn_q <= 1'b1;
			srg_pkg::ACT_DN_UP:       dn_q <= 1'b0;
			srg_pkg::ACT_CNT_INC:     cnt_q <= (dn_q ? down_q : up_q) + CW'(1);
			srg_pkg::ACT_MUL:         prod_q <= product;
			srg_pkg::ACT_EMIT: begin
				opulse_q  <= pulse_q;
				oen_q     <= en_q;
				oleft_q   <= left_q;
				oright_q  <= right_q;
				operiod_q <= cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			cur_q         <= srg_pkg::RESET_PERIOD;
			cur_dirs_q    <= srg_pkg::DIRS_FWD;
			tgt_period_q  <= srg_pkg::IDLE_MARK;
			tgt_dirs_q    <= srg_pkg::DIRS_FWD;
			prev_period_q <= srg_pkg::RESET_PERIOD;
			prev_dirs_q   <= srg_pkg::DIRS_FWD;
			decel_q       <= 1'b0;
			accel_q       <= 1'b0;
			up_q          <= '0;
			down_q        <= '0;
			pulse_q       <= 1'b0;
			en_q          <= 1'b1;
			left_q        <= 1'b1;
			right_q       <= 1'b1;
			ovalid_q      <= 1'b0;
		end else begin
			if (act == srg_pkg::ACT_EMIT) begin
				ovalid_q <= 1'b1;
			end else if (step_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			case (act)
				srg_pkg::ACT_LATCH:      pulse_q <= 1'b0;
				srg_pkg::ACT_SET_TARGET: begin
					tgt_dirs_q   <= req_dirs_q;
					tgt_period_q <= PW'(req_period_q);
				end
				srg_pkg::ACT_TICK_INC:   tick_q <= tick_q + TW'(1);
				srg_pkg::ACT_PULSE: begin
					tick_q  <= '0;
					pulse_q <= 1'b1;
				end
				srg_pkg::ACT_SEEK:       cur_dirs_q <= tgt_dirs_q;
				srg_pkg::ACT_ACCEL_START: begin
					cur_dirs_q <= tgt_dirs_q;
					accel_q    <= 1'b0;
				end
				srg_pkg::ACT_APPLY: begin
					if (reached) begin
						cur_q <= cur_stepped;
					end
					if (dn_q) begin
						down_q <= reached ? '0 : cnt_q;
					end else begin
						up_q <= reached ? '0 : cnt_q;
					end
				end
				srg_pkg::ACT_SAVE_PREV: begin
					// deceleration ends once the top period is reached
					if (decel_q && cur_q == top_period) begin
						decel_q <= 1'b0;
						accel_q <= 1'b1;
					end
					prev_period_q <= cur_q;
					prev_dirs_q   <= cur_dirs_q;
				end
				srg_pkg::ACT_DIRCHG: begin
					decel_q    <= 1'b1;
					cur_q      <= prev_period_q;
					cur_dirs_q <= prev_dirs_q;
				end
				srg_pkg::ACT_HOLD: begin
					cur_dirs_q    <= tgt_dirs_q;
					prev_period_q <= tgt_period_q;
					prev_dirs_q   <= tgt_dirs_q;
				end
				srg_pkg::ACT_LINES: begin
					if (cur_q == '0) begin
						en_q <= 1'b0;
					end else begin
						en_q    <= 1'b1;
						left_q  <= cur_dirs_q[0];
						right_q <= cur_dirs_q[1];
					end
				end
				default: ;
			endcase
		end
	end

endmodule

[rtl/stepper_pulse_ramp_generator.sv]
// Top level of the two-motor stepper pulse generator with period ramp.
//
//  port      role    payload
//  cmd_ch    sink    opcode, left_forward, right_forward, speed_period
//  step_ch   source  step_pulse, motor_enable, left_dir, right_dir, period_now
//  APB       slave   ramp_scale at 0x0, top_period at 0x4
//
// One item at a time, run by a microcoded step counter over a shared datapath.
// A pulsing tick at or below the top period also runs the ramp (ramp count,
// multiply, compare/apply each take one control step). The result register frees
// the datapath: a stalled result only holds the next item at its final step.
// Reset is asynchronous and needs no clearing pass.
module stepper_pulse_ramp_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	srg_in_if.sink                        cmd_ch,
	srg_out_if.source                     step_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [srg_pkg::ADDR_W-1:0]    paddr,
	input  logic [srg_pkg::DATA_W-1:0]    pwdata,
	output logic [srg_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	logic [srg_pkg::CNT_W-1:0] ramp_scale_q;
	logic [srg_pkg::PER_W-1:0] top_period_q;
	logic                      reg_sel;
	srg_pkg::status_t          status;
	srg_pkg::act_t             act;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_scale_q <= srg_pkg::RESET_SCALE;
			top_period_q <= srg_pkg::RESET_TOP;
		end else if (psel && penable && pwrite) begin
			if (reg_sel == srg_pkg::REG_RAMP_SCALE) begin
				ramp_scale_q <= pwdata[srg_pkg::CNT_W-1:0];
			end else begin
				top_period_q <= pwdata[srg_pkg::PER_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == srg_pkg::REG_RAMP_SCALE) begin
			prdata = srg_pkg::DATA_W'(ramp_scale_q);
		end else begin
			prdata = srg_pkg::DATA_W'(top_period_q);
		end
	end

	srg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.act    (act)
	);

	srg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.act        (act),
		.ramp_scale (ramp_scale_q),
		.top_period (top_period_q),
		.status     (status),
		.cmd_ch     (cmd_ch),
		.step_ch    (step_ch)
	);

endmodule

[verif/stepper_pulse_ramp_generator_tb.sv]
`timescale 1ns / 1ps
// Testbench for the stepper pulse ramp generator: random commands and ticks, checked per item.
module stepper_pulse_ramp_generator_tb;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;
	// slowest legal gap is a pulsing tick behind 80% random stalls
	localparam int unsigned STALL_LIMIT  = 5000;
	localparam int unsigned DRAIN_CYCLES = 20;

	typedef struct packed {
		logic       opcode;
		logic       left_forward;
		logic       right_forward;
		logic [3:0] speed_period;
	} motion_item_t;

	typedef struct packed {
		logic                      step_pulse;
		logic                      motor_enable;
		logic                      left_dir;
		logic                      right_dir;
		logic [srg_pkg::PER_W-1:0] period_now;
	} step_status_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [srg_pkg::ADDR_W-1:0] paddr;
	logic [srg_pkg::DATA_W-1:0] pwdata;
	logic [srg_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	srg_in_if  cmd_ch();
	srg_out_if step_ch();

	stepper_pulse_ramp_generator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_ch),
		.step_ch (step_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// motion state mirror
	logic [srg_pkg::CNT_W-1:0]  ramp_scale_q;
	logic [srg_pkg::PER_W-1:0]  top_period_q;
	logic [srg_pkg::TICK_W-1:0] ticks_q;
	logic [srg_pkg::PER_W-1:0]  period_q;
	logic [srg_pkg::PER_W-1:0]  goal_period_q;
	logic [srg_pkg::PER_W-1:0]  last_period_q;
	logic [1:0]                 dirs_q;
	logic [1:0]                 goal_dirs_q;
	logic [1:0]                 last_dirs_q;
	logic                       braking_q;
	logic                       speeding_q;
	logic [srg_pkg::CNT_W-1:0]  up_steps_q;
	logic [srg_pkg::CNT_W-1:0]  down_steps_q;
	logic                       en_line_q;
	logic                       left_line_q;
	logic                       right_line_q;

	motion_item_t pending_items[$];
	step_status_t expected_status[$];
	logic [1:0]   plan_dirs;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned items_queued;
	int unsigned items_accepted;
	int unsigned statuses_seen;
	int unsigned pulses_seen;
	int unsigned zero_period_pulses;
	int unsigned reg_writes;
	int unsigned mismatches;
	int unsigned quiet_cycles;

	function automatic void reset_motion_model();
		ramp_scale_q  = srg_pkg::RESET_SCALE;
		top_period_q  = srg_pkg::RESET_TOP;
		ticks_q       = '0;
		period_q      = srg_pkg::RESET_PERIOD;
		dirs_q        = srg_pkg::DIRS_FWD;
		goal_period_q = srg_pkg::IDLE_MARK;
		goal_dirs_q   = srg_pkg::DIRS_FWD;
		last_period_q = srg_pkg::RESET_PERIOD;
		last_dirs_q   = srg_pkg::DIRS_FWD;
		braking_q     = 1'b0;
		speeding_q    = 1'b0;
		up_steps_q    = '0;
		down_steps_q  = '0;
		en_line_q     = 1'b1;
		left_line_q   = 1'b1;
		right_line_q  = 1'b1;
	endfunction

	// one ramp count; the period moves once the count reaches scale / period
	function automatic void nudge_period(input logic up);
		logic [srg_pkg::CNT_W-1:0] quota;
		quota = ramp_scale_q / ((period_q == '0) ? 16'd1 : {9'd0, period_q});
		if (up) begin
			up_steps_q = up_steps_q + srg_pkg::CNT_W'(1);
			if (up_steps_q >= quota) begin
				if (period_q < srg_pkg::PERIOD_MAX)
					period_q = period_q + srg_pkg::PER_W'(1);
				up_steps_q = '0;
			end
		end else begin
			down_steps_q = down_steps_q + srg_pkg::CNT_W'(1);
			if (down_steps_q >= quota) begin
				if (period_q > '0)
					period_q = period_q - srg_pkg::PER_W'(1);
				down_steps_q = '0;
			end
		end
	endfunction

	function automatic void ramp_motion();
		if (period_q > top_period_q)
			return;
		if (speeding_q || braking_q) begin
			if (braking_q) begin
				nudge_period(1'b1);
				if (period_q == top_period_q) begin
					braking_q  = 1'b0;
					speeding_q = 1'b1;
				end
			end else begin
				dirs_q = goal_dirs_q;
				nudge_period(1'b0);
				speeding_q = 1'b0;
			end
			last_period_q = period_q;
			last_dirs_q   = dirs_q;
		end else if (last_dirs_q != goal_dirs_q) begin
			// reversal: fall back to the last settled state and start braking
			braking_q = 1'b1;
			period_q  = last_period_q;
			dirs_q    = last_dirs_q;
		end else if (period_q != goal_period_q) begin
			nudge_period(period_q < goal_period_q);
			dirs_q        = goal_dirs_q;
			last_period_q = period_q;
			last_dirs_q   = dirs_q;
		end else begin
			dirs_q        = goal_dirs_q;
			last_period_q = goal_period_q;
			last_dirs_q   = goal_dirs_q;
		end
	endfunction

	function automatic step_status_t step_motion(input motion_item_t it);
		step_status_t res;
		res.step_pulse = 1'b0;
		if (it.opcode == OP_CMD) begin
			goal_dirs_q   = {it.right_forward, it.left_forward};
			goal_period_q = {3'd0, it.speed_period};
		end else if (goal_period_q != srg_pkg::IDLE_MARK) begin
			ticks_q = ticks_q + srg_pkg::TICK_W'(1);
			if (ticks_q >= {1'b0, period_q}) begin
				res.step_pulse = 1'b1;
				ticks_q = '0;
				ramp_motion();
				if (period_q == '0) begin
					en_line_q = 1'b0;
				end else begin
					en_line_q    = 1'b1;
					left_line_q  = dirs_q[0];
					right_line_q = dirs_q[1];
				end
			end
		end
		res.motor_enable = en_line_q;
		res.left_dir     = left_line_q;
		res.right_dir    = right_line_q;
		res.period_now   = period_q;
		return res;
	endfunction

	function automatic void check_field(input string name,
			input logic [srg_pkg::PER_W-1:0] want, input logic [srg_pkg::PER_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic motion_item_t random_item();
		motion_item_t it;
		int unsigned  roll;
		it = motion_item_t'(7'($urandom));
		it.opcode = ($urandom_range(99) < 12) ? OP_CMD : OP_TICK;
		if (it.opcode == OP_CMD) begin
			// reversals stay rare so the ramp gets time to settle between them
			if ($urandom_range(99) < 75)
				{it.right_forward, it.left_forward} = plan_dirs;
			roll = $urandom_range(99);
			if (roll < 25)
				it.speed_period = 4'd0;
			else if (roll < 80)
				it.speed_period = 4'($urandom_range(9, 1));
			else
				it.speed_period = 4'($urandom_range(15, 10));
		end
		return it;
	endfunction

	task automatic enqueue(input motion_item_t it);
		if (it.opcode == OP_CMD)
			plan_dirs = {it.right_forward, it.left_forward};
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic enqueue_random(input int unsigned count);
		repeat (count) enqueue(random_item());
	endtask

	task automatic drain();
		while (items_accepted != items_queued || expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [srg_pkg::DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == srg_pkg::REG_RAMP_SCALE)
			ramp_scale_q = value[srg_pkg::CNT_W-1:0];
		else
			top_period_q = value[srg_pkg::PER_W-1:0];
		reg_writes++;
	endtask

	// upper bits of the bus carry junk that the registers must drop
	task automatic configure(input logic [srg_pkg::CNT_W-1:0] scale,
			input logic [srg_pkg::PER_W-1:0] top);
		write_reg(srg_pkg::REG_RAMP_SCALE, {16'($urandom), scale});
		write_reg(srg_pkg::REG_TOP_PERIOD, {25'($urandom), top});
	endtask

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin : feed_items
		motion_item_t nxt;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_status.push_back(step_motion({cmd_ch.opcode, cmd_ch.left_forward,
					cmd_ch.right_forward, cmd_ch.speed_period}));
				items_accepted++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_items.pop_front();
					cmd_ch.valid         <= 1'b1;
					cmd_ch.opcode        <= nxt.opcode;
					cmd_ch.left_forward  <= nxt.left_forward;
					cmd_ch.right_forward <= nxt.right_forward;
					cmd_ch.speed_period  <= nxt.speed_period;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_status
		step_status_t got;
		step_status_t want;
		if (arst_n) begin
			if (step_ch.valid && step_ch.ready) begin
				got.step_pulse   = step_ch.step_pulse;
				got.motor_enable = step_ch.motor_enable;
				got.left_dir     = step_ch.left_dir;
				got.right_dir    = step_ch.right_dir;
				got.period_now   = step_ch.period_now;
				statuses_seen++;
				if (expected_status.size() == 0) begin
					$error("status item with nothing outstanding");
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("step_pulse", srg_pkg::PER_W'(want.step_pulse),
						srg_pkg::PER_W'(got.step_pulse));
					check_field("motor_enable", srg_pkg::PER_W'(want.motor_enable),
						srg_pkg::PER_W'(got.motor_enable));
					check_field("left_dir", srg_pkg::PER_W'(want.left_dir),
						srg_pkg::PER_W'(got.left_dir));
					check_field("right_dir", srg_pkg::PER_W'(want.right_dir),
						srg_pkg::PER_W'(got.right_dir));
					check_field("period_now", want.period_now, got.period_now);
					if (want.step_pulse) begin
						pulses_seen++;
						if (want.period_now == '0)
							zero_period_pulses++;
					end
				end
			end
			step_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : watchdog
		if ((cmd_ch.valid && cmd_ch.ready) || (step_ch.valid && step_ch.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no item moved for %0d cycles", STALL_LIMIT);
			$display("stepper_pulse_ramp_generator_tb: errors");
			$finish;
		end
	end

	initial begin : run_test
		clk                  = 1'b0;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.opcode        = OP_TICK;
		cmd_ch.left_forward  = 1'b0;
		cmd_ch.right_forward = 1'b0;
		cmd_ch.speed_period  = '0;
		step_ch.ready        = 1'b0;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		items_queued         = 0;
		items_accepted       = 0;
		statuses_seen        = 0;
		pulses_seen          = 0;
		zero_period_pulses   = 0;
		reg_writes           = 0;
		mismatches           = 0;
		quiet_cycles         = 0;
		plan_dirs            = srg_pkg::DIRS_FWD;
		reset_motion_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: ticks before any command do nothing, then a slow start
		enqueue('{OP_TICK, 1'b1, 1'b0, 4'd15});
		enqueue('{OP_TICK, 1'b0, 1'b1, 4'd0});
		enqueue('{OP_CMD, 1'b1, 1'b1, 4'd15});
		repeat (10) enqueue('{OP_TICK, 1'b0, 1'b0, 4'd0});
		drain();

		// fast ramp, then a reversal overridden by a second command
		configure(16'd1, 7'd12);
		enqueue('{OP_CMD, 1'b0, 1'b1, 4'd9});
		enqueue('{OP_CMD, 1'b1, 1'b0, 4'd8});
		repeat (10) enqueue('{OP_TICK, 1'b1, 1'b1, 4'd7});
		drain();

		configure(16'd3, 7'd12);
		enqueue_random(350);
		drain();

		configure(16'd1, 7'd1);
		send_idle_pct = 80;
		enqueue_random(150);
		drain();

		configure(16'd65535, 7'd127);
		send_idle_pct  = 0;
		recv_stall_pct = 80;
		enqueue_random(120);
		drain();

		configure(16'($urandom_range(40, 1)), 7'($urandom_range(20, 10)));
		send_idle_pct  = 32;
		recv_stall_pct = 32;
		enqueue_random(200);
		// hold the sender until every outstanding status is back
		drain();
		enqueue_random(200);
		drain();

		configure(16'($urandom_range(60, 1)), 7'($urandom_range(30, 1)));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		enqueue_random(300);
		drain();

		configure(16'($urandom_range(20, 2)), 7'd15);
		send_idle_pct = 80;
		enqueue_random(250);
		drain();

		configure(16'($urandom_range(10, 1)), srg_pkg::RESET_TOP);
		send_idle_pct  = 0;
		recv_stall_pct = 80;
		enqueue_random(330);
		drain();

		$display("%0d items in, %0d status items checked, %0d register writes",
			items_accepted, statuses_seen, reg_writes);
		$display("%0d step pulses, %0d of them at period zero", pulses_seen,
			zero_period_pulses);
		if (mismatches == 0)
			$display("stepper_pulse_ramp_generator_tb: clean");
		else
			$display("stepper_pulse_ramp_generator_tb: errors");
		$finish;
	end

endmodule
